/* hdl/tint_pkg.sv */
package tint_pkg;

  localparam int unsigned TableDepth = 256;
  localparam logic signed [31:0] QOne = 32'sd65536;

  typedef enum logic [2:0] {
    ModeLinear  = 3'd0,
    ModeAverage = 3'd1,
    ModeNearest = 3'd2,
    ModeHoldA   = 3'd3,
    ModeHoldB   = 3'd4
  } interp_mode_e;

  typedef enum logic [1:0] {
    CfgInterp   = 2'd0,
    CfgExtrap   = 2'd1,
    CfgInterval = 2'd2,
    CfgLength   = 2'd3
  } cfg_index_e;

  typedef enum logic [3:0] {
    StIdle,
    StEnds,
    StEndsWait,
    StSearch,
    StSearchWait,
    StPair,
    StPairWait,
    StWeights,
    StDivide,
    StMulA,
    StMulB,
    StFinal,
    StAvgDiv,
    StOut
  } state_e;

endpackage

/* hdl/table_interpolator.sv */
// table_interpolator: point-table lookup, linear/average/nearest/hold modes, signed Q16.16
// a query reads both table ends, binary-searches between them for the bracketing pair and
// weights it; normalised weights take two 16-step serial divides, average mode a 64-step divide,
// and both use the shared restoring divider, while every table read goes through one read port
// the block takes one word at a time: s_axis_tready is low while a query is in work
// rst_ni resets the config registers, the control state and output valid; the table is not cleared
module table_interpolator
  import tint_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TableDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // operation, point_index, point_x, point_y, query_x, zero fill (112 bits)
  input  logic [111:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // value, extrapolated, mode_error, zero fill (40 bits)
  output logic [39:0] m_axis_tdata
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned NW = AW + 1;

  // configuration registers
  logic [2:0]         mode_q;
  logic               extrap_mode_q;
  logic signed [31:0] ti_q;
  logic [8:0]         len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= 3'd0;
      extrap_mode_q <= 1'b0;
      ti_q          <= -QOne;
      len_q         <= 9'd2;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgInterp:   mode_q        <= cfg_data_i[2:0];
        CfgExtrap:   extrap_mode_q <= cfg_data_i[0];
        CfgInterval: ti_q          <= cfg_data_i;
        CfgLength:   len_q         <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // input fields
  logic               in_op;
  logic [7:0]         in_idx;
  logic signed [31:0] in_px, in_py, in_qx;
  assign in_op  = s_axis_tdata[0];
  assign in_idx = s_axis_tdata[8:1];
  assign in_px  = s_axis_tdata[40:9];
  assign in_py  = s_axis_tdata[72:41];
  assign in_qx  = s_axis_tdata[104:73];

  // effective length, clamped to 1..depth
  logic [NW-1:0] n_eff;
  always_comb begin
    if (len_q == 9'd0) n_eff = NW'(1);
    else if (32'(len_q) > TABLE_DEPTH) n_eff = NW'(TABLE_DEPTH);
    else n_eff = NW'(len_q);
  end

  // table memory, one write and one read port, read data registered
  logic [63:0] mem [TABLE_DEPTH];
  logic [AW-1:0] rd_addr;
  logic [63:0]   rd_q;
  logic          wr_en;
  assign wr_en = s_axis_tvalid && s_axis_tready && !in_op
                 && (32'(in_idx) < TABLE_DEPTH);

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[AW'(in_idx)] <= {in_py, in_px};
    rd_q <= mem[rd_addr];
  end

  // sequencer state
  state_e state_q, state_d;
  logic signed [31:0] q_q;
  logic [NW-1:0] lo_q, hi_q;
  logic signed [31:0] xa_q, ya_q, x0_q, y0_q;
  logic signed [31:0] xb_q, yb_q;
  logic signed [33:0] wa_q, wb_q;
  logic signed [33:0] t_q;
  logic               extrap_q, first_q;
  logic               ends_first_q;
  logic [1:0]         hit_q; // 0 inside, 1 low end, 2 high end
  logic signed [65:0] s_q;
  logic signed [65:0] prod_q;
  logic signed [31:0] res_q;
  logic               ext_o_q, err_o_q;
  logic               out_v_q;

  // shared restoring divider: unsigned 64 / 33
  logic [63:0] dv_num_q;
  logic [63:0] dv_quo_q;
  logic [33:0] dv_rem_q;
  logic [32:0] dv_den_q;
  logic [6:0]  dv_cnt_q;
  logic [34:0] dv_trial;
  assign dv_trial = {dv_rem_q, dv_num_q[63]} - {2'b0, dv_den_q};

  // multiplier operands, one signed 34 x 32 product per cycle
  logic signed [33:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [65:0] mul_p;
  assign mul_p = mul_a * mul_b;

  logic [NW-1:0] mid;
  assign mid = NW'((lo_q + hi_q) >> 1);

  logic signed [31:0] rd_x, rd_y;
  assign rd_x = rd_q[31:0];
  assign rd_y = rd_q[63:32];

  logic signed [32:0] span;
  assign span = 33'(xb_q) - 33'(xa_q);

  // saturation to the signed 32-bit range
  function automatic logic signed [31:0] sat(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  logic [1:0] dv_phase_q; // 0 wb, 1 wa
  logic       avg_neg_q;

  always_comb begin
    state_d = state_q;
    rd_addr = '0;
    mul_a   = wa_q;
    mul_b   = ya_q;
    case (state_q)
      StIdle:             rd_addr = '0;
      StEnds, StEndsWait: rd_addr = AW'(n_eff - NW'(1));
      StSearch:           rd_addr = AW'(mid);
      StPair:             rd_addr = AW'(lo_q - NW'(1));
      StPairWait:         rd_addr = AW'(lo_q);
      StMulB: begin
        mul_a = wb_q;
        mul_b = yb_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_v_q <= 1'b0;
    end else begin
      if (state_q == StOut && (!out_v_q || m_axis_tready)) out_v_q <= 1'b1;
      else if (m_axis_tready) out_v_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (s_axis_tvalid && s_axis_tready && in_op) begin
            q_q <= in_qx;
            if (mode_q == ModeAverage && ti_q <= 0) begin
              res_q <= '0; ext_o_q <= 1'b0; err_o_q <= 1'b1;
              state_q <= StOut;
            end else begin
              err_o_q <= 1'b0;
              state_q <= StEnds; // address 0 read issued this cycle
            end
          end
        end
        StEnds: begin
          // rd_q holds entry 0; read of N-1 issued
          x0_q <= rd_x; y0_q <= rd_y;
          state_q <= StEndsWait;
        end
        StEndsWait: begin
          state_q <= StSearch;
          ends_first_q <= 1'b1;
        end
        StSearch: begin
          // first cycle here: rd_q holds entry N-1
          if (ends_first_q) begin
            ends_first_q <= 1'b0;
            t_q <= 34'(QOne);
            if (q_q <= x0_q) begin
              hit_q <= 2'd1; extrap_q <= (q_q < x0_q);
              wa_q <= 34'(QOne); wb_q <= '0;
              ya_q <= y0_q; yb_q <= y0_q;
              state_q <= StFinal;
            end else if (q_q >= rd_x) begin
              hit_q <= 2'd2; extrap_q <= (q_q > rd_x);
              wa_q <= '0; wb_q <= 34'(QOne);
              ya_q <= rd_y; yb_q <= rd_y;
              state_q <= StFinal;
            end else begin
              hit_q <= 2'd0; extrap_q <= 1'b0;
              lo_q <= NW'(1); hi_q <= n_eff - NW'(1);
              state_q <= StSearch;
            end
          end else if (lo_q < hi_q) begin
            state_q <= StSearchWait;
          end else begin
            state_q <= StPair;
          end
        end
        StSearchWait: begin
          if (rd_x < q_q) lo_q <= mid + NW'(1); else hi_q <= mid;
          state_q <= StSearch;
        end
        StPair: begin
          // rd_q will hold entry lo-1 next cycle; lo entry read earlier not kept, so fetch
          state_q <= StPairWait;
          first_q <= 1'b1;
        end
        StPairWait: begin
          if (first_q) begin
            xa_q <= rd_x; ya_q <= rd_y;
            first_q <= 1'b0;
            // read of entry lo now
          end else begin
            xb_q <= rd_x; yb_q <= rd_y;
            state_q <= StWeights;
          end
        end
        StWeights: begin
          if (ti_q < 0) begin
            if (span <= 0) begin
              wa_q <= '0; wb_q <= 34'(QOne);
              state_q <= StMulA;
            end else begin
              // numerator starts in the remainder, below the divisor, so 16 steps give q16
              dv_phase_q <= 2'd0;
              dv_den_q <= span; dv_num_q <= '0; dv_quo_q <= '0;
              if (33'(q_q) - 33'(xa_q) >= span) begin
                wb_q <= 34'(QOne);
                dv_rem_q <= '0; dv_cnt_q <= '0;
              end else begin
                dv_rem_q <= {1'b0, 33'(q_q) - 33'(xa_q)};
                dv_cnt_q <= 7'd16;
              end
              state_q <= StDivide;
            end
          end else begin
            if ((34'(q_q) - 34'(xa_q)) > 0 && (34'(q_q) - 34'(xa_q)) < 34'(ti_q)) begin
              wb_q <= 34'(q_q) - 34'(xa_q);
              wa_q <= 34'(ti_q) - (34'(q_q) - 34'(xa_q));
              t_q <= 34'(ti_q);
            end else begin
              wa_q <= '0; wb_q <= 34'(QOne);
            end
            state_q <= StMulA;
          end
        end
        StDivide: begin
          if (dv_cnt_q > 7'd1) begin
            dv_cnt_q <= dv_cnt_q - 7'd1;
            dv_num_q <= dv_num_q << 1;
            if (!dv_trial[34]) begin
              dv_rem_q <= dv_trial[33:0]; dv_quo_q <= {dv_quo_q[62:0], 1'b1};
            end else begin
              dv_rem_q <= {dv_rem_q[32:0], dv_num_q[63]}; dv_quo_q <= {dv_quo_q[62:0], 1'b0};
            end
          end else begin
            // step count 1 means last step, count 0 means result already set
            if (dv_cnt_q == 7'd1) begin
              if (dv_phase_q == 2'd0) wb_q <= 34'(dv_trial[34] ? {dv_quo_q[62:0], 1'b0}
                                                              : {dv_quo_q[62:0], 1'b1});
              else wa_q <= 34'(dv_trial[34] ? {dv_quo_q[62:0], 1'b0}
                                            : {dv_quo_q[62:0], 1'b1});
            end
            if (dv_phase_q == 2'd0) begin
              dv_phase_q <= 2'd1;
              dv_num_q <= '0; dv_quo_q <= '0;
              if (33'(xb_q) - 33'(q_q) >= span) begin
                wa_q <= 34'(QOne);
                dv_rem_q <= '0; dv_cnt_q <= '0;
              end else begin
                dv_rem_q <= {1'b0, 33'(xb_q) - 33'(q_q)};
                dv_cnt_q <= 7'd16;
              end
            end else begin
              state_q <= StMulA;
            end
          end
        end
        StMulA: begin
          prod_q <= mul_p;
          state_q <= StMulB;
        end
        StMulB: begin
          s_q <= prod_q + mul_p;
          state_q <= StFinal;
        end
        StFinal: begin
          ext_o_q <= extrap_q;
          if (extrap_q) begin
            res_q <= extrap_mode_q ? ((wa_q > wb_q) ? ya_q : yb_q) : '0;
            state_q <= StOut;
          end else if (hit_q != 2'd0 && (mode_q == ModeLinear || mode_q == ModeAverage)) begin
            // exact end hit: s = one * y, result is y
            res_q <= (hit_q == 2'd1) ? ya_q : yb_q;
            state_q <= StOut;
          end else begin
            case (mode_q)
              ModeLinear: begin
                res_q <= sat(s_q >>> 16);
                state_q <= StOut;
              end
              ModeAverage: begin
                avg_neg_q <= s_q[65];
                dv_num_q <= s_q[65] ? 64'(-s_q) : 64'(s_q);
                dv_den_q <= t_q[32:0];
                dv_rem_q <= '0; dv_quo_q <= '0;
                dv_cnt_q <= 7'd64;
                state_q <= StAvgDiv;
              end
              ModeNearest: begin res_q <= (wa_q > wb_q) ? ya_q : yb_q; state_q <= StOut; end
              ModeHoldA:   begin res_q <= ya_q; state_q <= StOut; end
              ModeHoldB:   begin res_q <= yb_q; state_q <= StOut; end
              default:     begin res_q <= '0; state_q <= StOut; end
            endcase
          end
        end
        StAvgDiv: begin
          dv_num_q <= dv_num_q << 1;
          if (!dv_trial[34]) begin
            dv_rem_q <= dv_trial[33:0]; dv_quo_q <= {dv_quo_q[62:0], 1'b1};
          end else begin
            dv_rem_q <= {dv_rem_q[32:0], dv_num_q[63]}; dv_quo_q <= {dv_quo_q[62:0], 1'b0};
          end
          dv_cnt_q <= dv_cnt_q - 7'd1;
          if (dv_cnt_q == 7'd0) begin
            res_q <= sat(avg_neg_q ? -$signed({2'b0, dv_quo_q}) : $signed({2'b0, dv_quo_q}));
            state_q <= StOut;
          end
        end
        StOut: begin
          if (!out_v_q || m_axis_tready) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  logic [39:0] out_q;
  always_ff @(posedge clk_i) begin
    if (state_q == StOut && (!out_v_q || m_axis_tready))
      out_q <= {6'b0, err_o_q, ext_o_q, res_q};
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  logic unused;
  assign unused = ^{s_axis_tdata[111:105], state_d};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !s_axis_tready)
    else $error("ready during query");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSearchWait) |-> (lo_q < hi_q))
    else $error("search bounds crossed");

endmodule

/* tb/tb_table_interpolator.sv */
module tb_table_interpolator;
  import tint_pkg::*;

  // one input word as the block sees it
  typedef struct packed {
    logic               op;
    logic [7:0]         idx;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] qx;
  } point_word_t;

  // one lookup result
  typedef struct packed {
    logic [31:0] value;
    logic        extrapolated;
    logic        mode_error;
  } lookup_t;

  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned DrainCycles = 200;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_index_i = '0;
  logic [31:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // operation, point_index, point_x, point_y, query_x, zero fill
  logic [111:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // value, extrapolated, mode_error, zero fill
  logic [39:0]  m_axis_tdata;

  table_interpolator uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mirror of the block's registers (set in write_reg) and of its point table (updated on accepted words)
  logic [2:0]         mode_m = ModeLinear;
  logic               extrap_m = 1'b0;
  logic signed [31:0] interval_m = -32'sd65536;
  logic [8:0]         length_m = 9'd2;
  logic signed [31:0] x_tab [TableDepth];
  logic signed [31:0] y_tab [TableDepth];

  // table as the stimulus generator last wrote it (same order as the block sees it)
  logic signed [31:0] gen_x [TableDepth];

  point_word_t pending_words [$];
  lookup_t     expected_lookups [$];
  point_word_t cur_word;
  int          send_idle = 0;
  int          recv_stall = 0;
  int          mismatches = 0;
  int unsigned quiet_cycles = 0;

  // clamped normalised weight num/den in Q16.16, den > 0
  function automatic longint norm_weight(longint num, longint den);
    if (num <= 0) return 0;
    if (num >= den) return 65536;
    return (num <<< 16) / den;
  endfunction

  function automatic lookup_t interp_lookup(logic signed [31:0] qx);
    lookup_t     r;
    int unsigned n, ia, ib, lo, hi, mid;
    longint      q, x0, xl, xa, xb, ya, yb, wa, wb, t, ti, s, v;
    bit          outside;
    r = '0;
    ti = interval_m;
    // averaging needs a positive interval
    if (mode_m == ModeAverage && ti <= 0) begin
      r.mode_error = 1'b1;
      return r;
    end
    n = length_m;
    if (n == 0) n = 1;
    if (n > TableDepth) n = TableDepth;
    q = qx;
    x0 = x_tab[0];
    xl = x_tab[n-1];
    t = 65536;
    if (q <= x0) begin
      ia = 0; ib = 0; wa = 65536; wb = 0; outside = (q < x0);
    end else if (q >= xl) begin
      ia = n - 1; ib = n - 1; wa = 0; wb = 65536; outside = (q > xl);
    end else begin
      outside = 1'b0;
      lo = 1; hi = n - 1;
      while (lo < hi) begin
        mid = (lo + hi) >> 1;
        if (longint'(x_tab[mid]) < q) lo = mid + 1;
        else hi = mid;
      end
      ib = lo; ia = lo - 1;
      xa = x_tab[ia];
      xb = x_tab[ib];
      if (ti < 0) begin
        // normalised weights, degenerate interval snaps to the upper point
        if (xb - xa <= 0) begin
          wa = 0; wb = 65536;
        end else begin
          wb = norm_weight(q - xa, xb - xa);
          wa = norm_weight(xb - q, xb - xa);
        end
      end else begin
        // raw distances inside the averaging interval
        wb = q - xa;
        wa = ti - wb;
        if (wb > 0 && wb < ti) begin
          t = ti;
        end else begin
          wa = 0; wb = 65536;
        end
      end
    end
    ya = y_tab[ia];
    yb = y_tab[ib];
    if (outside) begin
      v = extrap_m ? ((wa > wb) ? ya : yb) : 0;
    end else begin
      s = wa * ya + wb * yb;
      case (mode_m)
        ModeLinear:  v = s >>> 16;
        ModeAverage: v = s / t;
        ModeNearest: v = (wa > wb) ? ya : yb;
        ModeHoldA:   v = ya;
        ModeHoldB:   v = yb;
        default:     v = 0;
      endcase
    end
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    r.value = v[31:0];
    r.extrapolated = outside;
    return r;
  endfunction

  // driver: keeps tvalid high until the word is taken, random gaps between words
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (cur_word.op == 1'b0) begin
          x_tab[cur_word.idx] = cur_word.px;
          y_tab[cur_word.idx] = cur_word.py;
        end else begin
          expected_lookups.push_back(interp_lookup(cur_word.qx));
        end
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle) begin
          cur_word = pending_words.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {7'b0, cur_word.qx, cur_word.py, cur_word.px, cur_word.idx,
                           cur_word.op};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure, compare each result with the oldest expectation
  always @(posedge clk_i) begin
    lookup_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[31:0], m_axis_tdata[32], m_axis_tdata[33]};
        if (expected_lookups.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          mismatches++;
        end else begin
          want = expected_lookups.pop_front();
          if (got.value !== want.value) begin
            $display("%0t: value expected %h actual %h", $time, want.value, got.value);
            mismatches++;
          end
          if (got.extrapolated !== want.extrapolated) begin
            $display("%0t: extrapolated expected %b actual %b", $time,
                     want.extrapolated, got.extrapolated);
            mismatches++;
          end
          if (got.mode_error !== want.mode_error) begin
            $display("%0t: mode_error expected %b actual %b", $time,
                     want.mode_error, got.mode_error);
            mismatches++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // watchdog on cycles where nothing moves
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IdleLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic write_reg(cfg_index_e which, logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= which;
    cfg_data_i <= data;
    case (which)
      CfgInterp:   mode_m = data[2:0];
      CfgExtrap:   extrap_m = data[0];
      CfgInterval: interval_m = data;
      default:     length_m = data[8:0];
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_load(int unsigned idx, logic [31:0] px, logic [31:0] py);
    point_word_t w;
    w = '0;
    w.idx = idx[7:0];
    w.px = px;
    w.py = py;
    gen_x[idx[7:0]] = px;
    pending_words.push_back(w);
  endtask

  task automatic push_query(logic [31:0] qx);
    point_word_t w;
    w = '0;
    w.op = 1'b1;
    w.qx = qx;
    w.idx = 8'($urandom);
    w.px = $urandom;
    w.py = $urandom;
    pending_words.push_back(w);
  endtask

  // sorted table with random spacing; step_max sets how dense it is
  task automatic fill_sorted_table(longint step_max, bit wide_y);
    longint room, acc;
    logic [31:0] y;
    room = 64'd4294967295 - 255 * step_max;
    acc = -64'sd2147483648 + (longint'($urandom) % room);
    if ($urandom_range(3) == 0) acc = -64'sd2147483648;
    for (int k = 0; k < TableDepth; k++) begin
      if (wide_y) y = $urandom;
      else y = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      if (k == 0 && wide_y) y = 32'h8000_0000;
      if (k == TableDepth - 1 && wide_y) y = 32'h7fff_ffff;
      push_load(k, acc[31:0], y);
      acc += 1 + (longint'($urandom) % step_max);
    end
  endtask

  function automatic logic [31:0] pick_query(int unsigned n);
    int unsigned k;
    longint gap;
    k = $urandom_range(n - 1);
    case ($urandom_range(7))
      0:       return $urandom;
      1, 2:    return gen_x[k];
      3:       return gen_x[k] + $urandom_range(6) - 3;
      4:       return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: begin
        if (k + 1 >= n) return gen_x[k] - $urandom_range(65536);
        gap = longint'(gen_x[k+1]) - longint'(gen_x[k]);
        if (gap <= 0) return gen_x[k];
        return 32'(longint'(gen_x[k]) + (longint'($urandom) % (gap + 1)));
      end
    endcase
  endfunction

  task automatic wait_idle();
    while (pending_words.size() != 0 || s_axis_tvalid || expected_lookups.size() != 0)
      @(posedge clk_i);
    // extra idle time before the next phase writes the registers
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] interval_v;
    logic [8:0]  length_v;
    int unsigned n_eff;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < 12; p++) begin
      case (p % 6)
        0: interval_v = -32'sd65536;
        1: interval_v = 32'sd65536;
        2: interval_v = 32'sd0;
        3: interval_v = 32'h7fff_ffff;
        4: interval_v = 32'h8000_0000;
        default: interval_v = $urandom_range(32'h0010_0000, 1);
      endcase
      // average mode with no interval flags an error
      if (p == 9) interval_v = 32'sd0;
      case (p)
        0:  length_v = 9'd256;
        1:  length_v = 9'd1;
        2:  length_v = 9'd2;
        3:  length_v = 9'd0;
        4:  length_v = 9'd511;
        5:  length_v = 9'd3;
        6:  length_v = 9'd16;
        7:  length_v = 9'd257;
        default: length_v = $urandom_range(256, 1);
      endcase
      write_reg(CfgInterp, p % 8);
      write_reg(CfgExtrap, p % 2);
      write_reg(CfgInterval, interval_v);
      write_reg(CfgLength, length_v);

      case (p % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 52; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 52; end
        default: begin send_idle = 36; recv_stall = 36; end
      endcase

      // fresh sorted table every fourth phase, the first one writes every entry
      // so no lookup touches an unwritten point; dense spacing makes the averaging window hit
      if (p % 4 == 0) begin
        case ($urandom_range(2))
          0: fill_sorted_table(8, 1'b0);
          1: fill_sorted_table(64'd1 << 17, $urandom_range(1));
          default: fill_sorted_table(64'd1 << 23, 1'b1);
        endcase
      end

      n_eff = (length_v == 0) ? 1 : (length_v > TableDepth ? TableDepth : length_v);

      // table ends, just past them, and the query extremes
      push_query(gen_x[0]);
      push_query(gen_x[0] - 1);
      push_query(gen_x[n_eff-1]);
      push_query(gen_x[n_eff-1] + 1);
      push_query(32'h8000_0000);
      push_query(32'h7fff_ffff);

      for (int i = 0; i < 59; i++) begin
        if ($urandom_range(99) < 8) begin
          // stray load, may leave the table unsorted
          push_load($urandom_range(255), $urandom, $urandom);
        end else begin
          push_query(pick_query(n_eff));
        end
      end
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
